// ===== hw/rtl/taat_pkg.sv =====
package taat_pkg;
   localparam int TABLE_DEPTH = 64;
   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int NCAND = 8;

   localparam logic [2:0] REQ_LOOKUP_ADDR = 3'd0;
   localparam logic [2:0] REQ_LOOKUP_ID   = 3'd1;
   localparam logic [2:0] REQ_RELEASE     = 3'd2;
   localparam logic [2:0] REQ_SET         = 3'd3;
   localparam logic [2:0] REQ_ALLOCATE    = 3'd4;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_NOT_FOUND = 3'd1;
   localparam logic [2:0] ST_FULL      = 3'd2;
   localparam logic [2:0] ST_NO_FREE   = 3'd3;
   localparam logic [2:0] ST_INVALID   = 3'd4;

   localparam logic [1:0] CSR_DEFAULT_ADDR = 2'd0;
   localparam logic [1:0] CSR_MAX_CHILDREN = 2'd1;
   localparam logic [1:0] CSR_BLANK_ADDR   = 2'd2;

   typedef struct packed {
      logic [2:0]  kind;
      logic [7:0]  node_id;
      logic [15:0] address;
   } scan_req_type;

   // Per-entry match flags returned by the compare unit.
   typedef struct packed {
      logic             id_hit;
      logic             addr_hit;
      logic [NCAND-1:0] cand_taken;
   } scan_hit_type;
endpackage

// ===== hw/rtl/taat_compare.sv =====
module taat_compare (
   input  taat_pkg::scan_req_type                    req,
   input  logic [taat_pkg::NCAND-1:0][15:0]          cand,
   input  logic [7:0]                                ent_id,
   input  logic [15:0]                               ent_addr,
   output taat_pkg::scan_hit_type                    hit
);
   import taat_pkg::*;

   always_comb begin
      hit.id_hit   = (ent_id == req.node_id);
      hit.addr_hit = (ent_addr == req.address);
      for (int k = 0; k < NCAND; k++) begin
         hit.cand_taken[k] = (ent_addr == cand[k]) && (ent_id != req.node_id);
      end
   end
endmodule

// ===== hw/rtl/tree_address_allocation_table.sv =====
// Flow: a request taken while idle passes through PREP, which counts the octal digits of a
// non-default forwarder address, then SCAN over the stored entries, then EVAL and DONE.
// Throughput: one request at a time; busy stays high through the response cycle, so the
// next request is taken in the cycle after the response at the earliest.
// Reset (synchronous, active high) empties the table and loads CSR defaults; the receiver
// cannot stall, and each response is shown for exactly one cycle.
module tree_address_allocation_table (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_type,
   input  logic [7:0]  req_node_id,
   input  logic [15:0] req_address,
   input  logic [15:0] req_forwarder_address,
   output logic        rsp_valid,
   output logic [2:0]  rsp_status,
   output logic [15:0] rsp_out_address,
   output logic [7:0]  rsp_out_node_id,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);
   import taat_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_PREP = 3'd1;
   localparam logic [2:0] S_SCAN = 3'd2;
   localparam logic [2:0] S_EVAL = 3'd3;
   localparam logic [2:0] S_DONE = 3'd4;

   logic [7:0]  mem_id [TABLE_DEPTH];
   logic [15:0] mem_addr [TABLE_DEPTH];

   logic [2:0]  state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [15:0] dflt_ff, blank_ff;
   logic [2:0]  maxc_ff;
   scan_req_type req_ff;
   logic [15:0] fwd_ff;
   logic [NCAND-1:0][15:0] cand_ff;
   logic [NCAND-1:0] cand_ok_ff;
   logic [NCAND-1:0] taken_ff, taken_in;
   logic        id_found_ff, id_found_in, addr_found_ff, addr_found_in;
   logic [IDX_W-1:0] id_idx_ff, id_idx_in, addr_idx_ff, addr_idx_in;
   logic [7:0]  id_val_ff, id_val_in;
   logic [15:0] addr_val_ff, addr_val_in;
   logic [7:0]  rd_id_ff;
   logic [15:0] rd_addr_ff;
   logic        rd_valid_ff;
   logic        rsp_valid_ff;
   logic [2:0]  st_ff;
   logic [15:0] oaddr_ff;
   logic [7:0]  oid_ff;
   logic [4:0]  shift_ff;
   logic [15:0] shm_ff;

   scan_hit_type hit;
   taat_compare u_cmp (.req(req_ff), .cand(cand_ff), .ent_id(rd_id_ff),
                       .ent_addr(rd_addr_ff), .hit(hit));

   assign busy            = (state_ff != S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = st_ff;
   assign rsp_out_address = oaddr_ff;
   assign rsp_out_node_id = oid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dflt_ff  <= 16'd2340;
         maxc_ff  <= 3'd4;
         blank_ff <= 16'hFFFF;
      end else if (csr_write) begin
         case (csr_index)
            CSR_DEFAULT_ADDR: dflt_ff  <= csr_data;
            CSR_MAX_CHILDREN: maxc_ff  <= csr_data[2:0];
            CSR_BLANK_ADDR:   blank_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Sequencer control.
   logic scan_more;
   assign scan_more = (idx_ff < count_ff);

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      case (state_ff)
         S_IDLE: if (start) begin
            state_in = S_PREP;
         end
         S_PREP: begin
            if (shm_ff == 16'd0) begin
               state_in = S_SCAN;
               idx_in   = '0;
            end
         end
         S_SCAN: begin
            if (scan_more) idx_in = idx_ff + 1'b1;
            else if (!rd_valid_ff) state_in = S_EVAL;
         end
         S_EVAL: state_in = S_DONE;
         S_DONE: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) rd_valid_ff <= 1'b0;
      else rd_valid_ff <= (state_ff == S_SCAN) && scan_more;
   end
   always_ff @(posedge clock) begin
      if (state_ff == S_SCAN && scan_more) begin
         rd_id_ff   <= mem_id[idx_ff[IDX_W-1:0]];
         rd_addr_ff <= mem_addr[idx_ff[IDX_W-1:0]];
      end
   end

   logic [IDX_W-1:0] rd_idx_ff;
   always_ff @(posedge clock) rd_idx_ff <= idx_ff[IDX_W-1:0];

   // Accumulate first matches across the scan.
   always_comb begin
      id_found_in   = id_found_ff;
      addr_found_in = addr_found_ff;
      id_idx_in     = id_idx_ff;
      addr_idx_in   = addr_idx_ff;
      id_val_in     = id_val_ff;
      addr_val_in   = addr_val_ff;
      taken_in      = taken_ff;
      if (state_ff == S_PREP) begin
         id_found_in = 1'b0;
         addr_found_in = 1'b0;
         taken_in = '0;
      end else if (state_ff == S_SCAN && rd_valid_ff) begin
         if (hit.id_hit && !id_found_ff) begin
            id_found_in = 1'b1;
            id_idx_in   = rd_idx_ff;
            addr_val_in = rd_addr_ff;
         end
         if (hit.addr_hit && !addr_found_ff) begin
            addr_found_in = 1'b1;
            addr_idx_in   = rd_idx_ff;
            id_val_in     = rd_id_ff;
         end
         taken_in = taken_ff | hit.cand_taken;
      end
   end

   always_ff @(posedge clock) begin
      id_found_ff   <= id_found_in;
      addr_found_ff <= addr_found_in;
      id_idx_ff     <= id_idx_in;
      addr_idx_ff   <= addr_idx_in;
      id_val_ff     <= id_val_in;
      addr_val_ff   <= addr_val_in;
      taken_ff      <= taken_in;
   end

   // Capture the request and count the forwarder's octal digits one per cycle.
   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && start) begin
         req_ff.kind    <= req_type;
         req_ff.node_id <= req_node_id;
         req_ff.address <= req_address;
         fwd_ff         <= req_forwarder_address;
         shift_ff       <= '0;
         shm_ff         <= (req_forwarder_address == dflt_ff) ? 16'd0
                                                              : req_forwarder_address;
      end else if (state_ff == S_PREP && shm_ff != 16'd0) begin
         shm_ff   <= shm_ff >> 3;
         shift_ff <= shift_ff + 5'd3;
      end
   end

   // Candidate digit k+1 follows the parent; valid up to the digit limit unless default.
   logic        lvl1;
   logic [3:0]  dlimit;
   assign lvl1   = (fwd_ff == dflt_ff);
   assign dlimit = {1'b0, maxc_ff} + {3'b0, lvl1};
   always_ff @(posedge clock) begin
      if (state_ff == S_PREP && shm_ff == 16'd0) begin
         for (int k = 0; k < NCAND; k++) begin
            logic [31:0] c;
            c = (lvl1 ? 32'd0 : {16'd0, fwd_ff}) | (32'(k + 1) << shift_ff);
            cand_ff[k]    <= c[15:0];
            cand_ok_ff[k] <= (4'(k + 1) <= dlimit) && (c[15:0] != dflt_ff);
         end
      end
   end

   // Highest free candidate digit wins.
   logic [NCAND-1:0] free_v;
   logic             any_free;
   logic [15:0]      pick;
   always_comb begin
      free_v   = cand_ok_ff & ~taken_ff;
      any_free = 1'b0;
      pick     = '0;
      for (int k = 0; k < NCAND; k++) begin
         if (free_v[k]) begin
            any_free = 1'b1;
            pick     = cand_ff[k];
         end
      end
   end

   logic full;
   assign full = (count_ff >= CNT_W'(TABLE_DEPTH));

   logic             wr_en;
   logic [IDX_W-1:0] wr_idx;
   logic [7:0]       wr_id;
   logic [15:0]      wr_addr;
   logic             wr_id_en;
   logic [2:0]       st_in;
   logic [15:0]      oaddr_in;
   logic [7:0]       oid_in;

   always_comb begin
      wr_en    = 1'b0;
      wr_id_en = 1'b0;
      wr_idx   = id_idx_ff;
      wr_id    = req_ff.node_id;
      wr_addr  = req_ff.address;
      st_in    = ST_NOT_FOUND;
      oaddr_in = '0;
      oid_in   = '0;
      count_in = count_ff;
      case (req_ff.kind)
         REQ_LOOKUP_ADDR: begin
            if (req_ff.node_id == 8'd0) st_in = ST_OK;
            else if (id_found_ff) begin
               st_in = ST_OK;
               oaddr_in = addr_val_ff;
            end
         end
         REQ_LOOKUP_ID: begin
            if (req_ff.address == blank_ff || req_ff.address == 16'd0) st_in = ST_OK;
            else if (addr_found_ff) begin
               st_in  = ST_OK;
               oid_in = id_val_ff;
            end
         end
         REQ_RELEASE: begin
            if (addr_found_ff) begin
               st_in   = ST_OK;
               wr_en   = 1'b1;
               wr_idx  = addr_idx_ff;
               wr_addr = 16'd0;
            end
         end
         REQ_SET, REQ_ALLOCATE: begin
            if (req_ff.kind == REQ_ALLOCATE) begin
               wr_addr = pick;
            end
            if (req_ff.kind == REQ_ALLOCATE && req_ff.node_id == 8'd0) begin
               st_in = ST_INVALID;
            end else if (req_ff.kind == REQ_ALLOCATE && !any_free) begin
               st_in = ST_NO_FREE;
            end else if (id_found_ff) begin
               st_in = ST_OK;
               wr_en = 1'b1;
               oaddr_in = (req_ff.kind == REQ_ALLOCATE) ? pick : 16'd0;
            end else if (full) begin
               st_in = ST_FULL;
            end else begin
               st_in    = ST_OK;
               wr_en    = 1'b1;
               wr_id_en = 1'b1;
               wr_idx   = count_ff[IDX_W-1:0];
               count_in = count_ff + 1'b1;
               oaddr_in = (req_ff.kind == REQ_ALLOCATE) ? pick : 16'd0;
            end
         end
         default: st_in = ST_INVALID;
      endcase
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_EVAL && wr_en) begin
         mem_addr[wr_idx] <= wr_addr;
         if (wr_id_en) mem_id[wr_idx] <= wr_id;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= (state_ff == S_EVAL);
         if (state_ff == S_EVAL) count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_EVAL) begin
         st_ff    <= st_in;
         oaddr_ff <= oaddr_in;
         oid_ff   <= oid_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_DEPTH)) else $error("entry count overflow");
   a_rsp_after_eval: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff) == S_EVAL) else $error("stray response");
   a_busy_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("response while idle");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_EVAL |=> $stable(count_ff)) else $error("count changed outside commit");
endmodule
